@@ src/bspl_pkg.sv @@
// Shared types and constants for the BSP point locate block.
// Used by bspl_ctrl, bspl_dp and bsp_point_locate_core; no dependencies.
package bspl_pkg;

   localparam int NODE_DEPTH = 4096;
   localparam int MAX_HOPS   = 64;
   localparam int NODE_AW    = $clog2(NODE_DEPTH);
   localparam int HOP_W      = $clog2(MAX_HOPS + 1);
   localparam int COUNT_W    = 13;
   localparam int LINK_W     = 16;
   localparam int SUB_W      = 15;
   localparam int COORD_W    = 16;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_LOCATE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FETCH,
      ST_CROSS,
      ST_DONE
   } bspl_state_type;

   typedef struct packed {
      logic write_node;
      logic load_root;
      logic fetch;
      logic latch_prod;
      logic step;
      logic finish_hit;
      logic finish_fail;
      logic finish_empty;
   } bspl_cmd_type;

   typedef struct packed {
      logic empty;
      logic is_leaf;
      logic bad_node;
      logic hop_limit;
   } bspl_status_type;

endpackage

@@ src/bsp_point_locate_core.sv @@
// BSP point locate: a node write gives no result and leaves the block idle.
// A locate stays busy while it walks the tree and strobes its item on rsp_valid
// in the last cycle that it is busy; each internal node on the walk costs a table read,
// a multiply step and a compare-and-step. An empty table answers without a walk.
// Reset clears node_count and the controller; the node table holds its contents.
// The receiver cannot stall: every result is taken in its strobe cycle.
module bsp_point_locate_core
   import bspl_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_mode,
   input  logic [11:0]                req_node_index,
   input  logic signed [COORD_W-1:0]  req_line_start_x,
   input  logic signed [COORD_W-1:0]  req_line_start_y,
   input  logic signed [COORD_W-1:0]  req_line_delta_x,
   input  logic signed [COORD_W-1:0]  req_line_delta_y,
   input  logic [LINK_W-1:0]          req_first_child,
   input  logic [LINK_W-1:0]          req_second_child,
   input  logic signed [COORD_W-1:0]  req_query_x,
   input  logic signed [COORD_W-1:0]  req_query_y,
   output logic                       rsp_valid,
   output logic [SUB_W-1:0]           rsp_subsector_index,
   output logic                       rsp_walk_error,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [COUNT_W-1:0]         csr_node_count
);

   bspl_cmd_type    cmd;
   bspl_status_type status;

   assign csr_ready = !busy;

   bspl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bspl_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_valid && csr_ready),
      .csr_node_count      (csr_node_count),
      .req_node_index      (req_node_index),
      .req_line_start_x    (req_line_start_x),
      .req_line_start_y    (req_line_start_y),
      .req_line_delta_x    (req_line_delta_x),
      .req_line_delta_y    (req_line_delta_y),
      .req_first_child     (req_first_child),
      .req_second_child    (req_second_child),
      .req_query_x         (req_query_x),
      .req_query_y         (req_query_y),
      .rsp_subsector_index (rsp_subsector_index),
      .rsp_walk_error      (rsp_walk_error)
   );

endmodule

@@ src/bspl_ctrl.sv @@
// Walk controller for the BSP point locate block: sequences node reads and side tests.
// Depends on bspl_pkg for the state and command/status types.
module bspl_ctrl
   import bspl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            req_mode,
   input  bspl_status_type status,
   output bspl_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_valid
);

   bspl_state_type state_ff;
   bspl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_mode == MODE_LOCATE) begin
               state_in = status.empty ? ST_DONE : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.is_leaf || status.bad_node || status.hop_limit) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_CROSS;
         ST_CROSS: state_in = ST_CHECK;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start && req_mode == MODE_WRITE) begin
               cmd.write_node = 1'b1;
            end
            if (start && req_mode == MODE_LOCATE) begin
               cmd.load_root    = !status.empty;
               cmd.finish_empty = status.empty;
            end
         end
         ST_CHECK: begin
            if (status.is_leaf) begin
               cmd.finish_hit = 1'b1;
            end else if (status.bad_node || status.hop_limit) begin
               cmd.finish_fail = 1'b1;
            end else begin
               cmd.fetch = 1'b1;
            end
         end
         ST_FETCH: cmd.latch_prod = 1'b1;
         ST_CROSS: cmd.step = 1'b1;
         ST_DONE:  rsp_valid = 1'b1;
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_fetch_then_cross: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |=> (state_ff == ST_CROSS))
      else $error("node read not followed by side test");

   a_fail_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && !status.is_leaf && (status.bad_node || status.hop_limit))
      |=> (state_ff == ST_DONE))
      else $error("failed walk did not terminate");

   a_start_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && req_mode == MODE_LOCATE) |=> busy)
      else $error("locate item accepted but block not busy");

endmodule

@@ src/bspl_dp.sv @@
// Datapath for the BSP point locate block: node table, walk pointer, hop count,
// cross product side test and result registers. Depends on bspl_pkg.
module bspl_dp
   import bspl_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  bspl_cmd_type               cmd,
   output bspl_status_type            status,
   input  logic                       csr_we,
   input  logic [COUNT_W-1:0]         csr_node_count,
   input  logic [11:0]                req_node_index,
   input  logic signed [COORD_W-1:0]  req_line_start_x,
   input  logic signed [COORD_W-1:0]  req_line_start_y,
   input  logic signed [COORD_W-1:0]  req_line_delta_x,
   input  logic signed [COORD_W-1:0]  req_line_delta_y,
   input  logic [LINK_W-1:0]          req_first_child,
   input  logic [LINK_W-1:0]          req_second_child,
   input  logic signed [COORD_W-1:0]  req_query_x,
   input  logic signed [COORD_W-1:0]  req_query_y,
   output logic [SUB_W-1:0]           rsp_subsector_index,
   output logic                       rsp_walk_error
);

   logic [4*COORD_W-1:0]        node_lines [NODE_DEPTH];
   logic [2*LINK_W-1:0]         node_links [NODE_DEPTH];

   logic [COUNT_W-1:0]          node_count_ff;
   logic [LINK_W-1:0]           cur_ff;
   logic [LINK_W-1:0]           cur_in;
   logic [HOP_W-1:0]            hops_ff;
   logic signed [COORD_W-1:0]   qx_ff;
   logic signed [COORD_W-1:0]   qy_ff;
   logic [4*COORD_W-1:0]        line_ff;
   logic [2*LINK_W-1:0]         links_ff;
   logic signed [2*COORD_W:0]   p1_ff;
   logic signed [2*COORD_W:0]   p2_ff;
   logic signed [2*COORD_W:0]   p1_in;
   logic signed [2*COORD_W:0]   p2_in;
   logic signed [COORD_W:0]     a_diff;
   logic signed [COORD_W:0]     b_diff;
   logic signed [COORD_W-1:0]   l_dx;
   logic signed [COORD_W-1:0]   l_dy;
   logic signed [2*COORD_W+1:0] side_sum;
   logic [SUB_W-1:0]            sub_ff;
   logic                        err_ff;
   logic                        write_ok;

   assign write_ok = 32'(req_node_index) < NODE_DEPTH;

   always_ff @(posedge clock) begin
      if (cmd.write_node && write_ok) begin
         node_lines[NODE_AW'(req_node_index)] <= {req_line_delta_y, req_line_delta_x,
                                                  req_line_start_y, req_line_start_x};
         node_links[NODE_AW'(req_node_index)] <= {req_second_child, req_first_child};
      end
      if (cmd.fetch) begin
         line_ff  <= node_lines[cur_ff[NODE_AW-1:0]];
         links_ff <= node_links[cur_ff[NODE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else if (csr_we) begin
         node_count_ff <= csr_node_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hops_ff <= '0;
      end else if (cmd.load_root) begin
         hops_ff <= '0;
      end else if (cmd.fetch) begin
         hops_ff <= hops_ff + HOP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_root) begin
         cur_ff <= LINK_W'(node_count_ff - COUNT_W'(1));
         qx_ff  <= req_query_x;
         qy_ff  <= req_query_y;
      end else if (cmd.step) begin
         cur_ff <= cur_in;
      end
      if (cmd.latch_prod) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   always_comb begin
      a_diff   = {line_ff[COORD_W-1], line_ff[COORD_W-1:0]} - {qx_ff[COORD_W-1], qx_ff};
      b_diff   = {line_ff[2*COORD_W-1], line_ff[2*COORD_W-1:COORD_W]}
                 - {qy_ff[COORD_W-1], qy_ff};
      l_dx     = line_ff[3*COORD_W-1:2*COORD_W];
      l_dy     = line_ff[4*COORD_W-1:3*COORD_W];
      p1_in    = a_diff * l_dy;
      p2_in    = b_diff * l_dx;
      side_sum = p1_ff - p2_ff;
      cur_in   = side_sum[2*COORD_W+1] ? links_ff[LINK_W-1:0]
                                       : links_ff[2*LINK_W-1:LINK_W];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_hit) begin
         sub_ff <= cur_ff[SUB_W-1:0];
         err_ff <= 1'b0;
      end else if (cmd.finish_fail) begin
         sub_ff <= '0;
         err_ff <= 1'b1;
      end else if (cmd.finish_empty) begin
         sub_ff <= '0;
         err_ff <= 1'b0;
      end
   end

   always_comb begin
      status.empty     = node_count_ff == '0;
      status.is_leaf   = cur_ff[LINK_W-1];
      status.bad_node  = (cur_ff >= LINK_W'(node_count_ff)) || (32'(cur_ff) >= NODE_DEPTH);
      status.hop_limit = hops_ff >= HOP_W'(MAX_HOPS);
   end

   assign rsp_subsector_index = sub_ff;
   assign rsp_walk_error      = err_ff;

endmodule
